@@ sv/oblu_pkg.sv @@
// Shared types and constants for the order book level update block.
// No dependencies.
`timescale 1ns / 1ps
package oblu_pkg;
    localparam int BOOK_DEPTH = 64;
    localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);
    localparam int PRICE_W    = 31;
    localparam int VOL_W      = 48;
    localparam int LVL_W      = 7;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;
    localparam logic SIDE_BID   = 1'b0;
    localparam logic SIDE_ASK   = 1'b1;

    typedef struct packed {
        logic load;
        logic apply;
    } t_dp_cmd;

    typedef struct packed {
        logic clear;
    } t_dp_sts;
endpackage

@@ sv/oblu_side.sv @@
// One side of the book: a compare-and-shift row of price and volume cells.
// Depends on oblu_pkg.
`timescale 1ns / 1ps
module oblu_side (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_is_ask,
    input  logic                                i_clear,
    input  logic                                i_apply,
    input  logic [oblu_pkg::PRICE_W-1:0]        i_price,
    input  logic [oblu_pkg::VOL_W-1:0]          i_volume,
    output logic [oblu_pkg::PRICE_W-1:0]        o_top_price,
    output logic [oblu_pkg::VOL_W-1:0]          o_top_volume,
    output logic [oblu_pkg::CNT_W-1:0]          o_count,
    output logic                                o_overflow
);
    localparam int D = oblu_pkg::BOOK_DEPTH;

    logic [oblu_pkg::PRICE_W-1:0] r_price [D];
    logic [oblu_pkg::VOL_W-1:0]   r_vol   [D];
    logic [oblu_pkg::CNT_W-1:0]   r_count, n_count;
    logic [D-1:0] valid, eq, behind, ge_pos;
    logic         hit, vz, full, ins, del;

    always_comb begin
        for (int k = 0; k < D; k++) begin
            valid[k]  = (oblu_pkg::CNT_W'(k) < r_count);
            eq[k]     = valid[k] && (r_price[k] == i_price);
            behind[k] = valid[k] && (i_is_ask ? (i_price < r_price[k])
                                              : (i_price > r_price[k]));
        end
        // position at or after first equal-or-behind entry; invalid tail counts too
        ge_pos[0] = eq[0] || behind[0] || !valid[0];
        for (int k = 1; k < D; k++)
            ge_pos[k] = ge_pos[k-1] || eq[k] || behind[k] || !valid[k];
    end

    assign hit  = |eq;
    assign vz   = (i_volume == '0);
    assign full = (r_count == oblu_pkg::CNT_W'(D));
    assign del  = i_apply && hit && vz;
    assign ins  = i_apply && !hit && !vz;

    always_comb begin
        n_count = r_count;
        if (i_clear) n_count = '0;
        else if (del) n_count = r_count - 1'b1;
        else if (ins && !full) n_count = r_count + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            o_overflow <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_apply || i_clear) o_overflow <= ins && full && !i_clear;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < D; k++) begin
            if (i_apply && hit && !vz && eq[k]) r_vol[k] <= i_volume;
            if (del && ge_pos[k] && k + 1 < D) begin
                r_price[k] <= r_price[(k + 1) % D];
                r_vol[k]   <= r_vol[(k + 1) % D];
            end
            if (ins && ge_pos[k]) begin
                if (k == 0 || !ge_pos[(k + D - 1) % D]) begin
                    r_price[k] <= i_price;
                    r_vol[k]   <= i_volume;
                end else begin
                    r_price[k] <= r_price[(k + D - 1) % D];
                    r_vol[k]   <= r_vol[(k + D - 1) % D];
                end
            end
        end
    end

    assign o_top_price  = (r_count != '0) ? r_price[0] : '0;
    assign o_top_volume = (r_count != '0) ? r_vol[0] : '0;
    assign o_count      = r_count;

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= oblu_pkg::CNT_W'(D)) else $error("count above depth");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> r_count == '0) else $error("clear left levels");
    a_del: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        del && !i_clear |=> r_count == $past(r_count) - 1'b1)
        else $error("delete count");
`endif
endmodule

@@ sv/oblu_dp.sv @@
// Datapath: input hold register, both book sides, result register.
// Depends on oblu_pkg and oblu_side.
`timescale 1ns / 1ps
module oblu_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  oblu_pkg::t_dp_cmd            i_cmd,
    output oblu_pkg::t_dp_sts            o_sts,
    input  logic                         i_cmd_bit,
    input  logic                         i_side,
    input  logic [oblu_pkg::PRICE_W-1:0] i_level_price,
    input  logic [oblu_pkg::VOL_W-1:0]   i_level_volume,
    output logic [oblu_pkg::PRICE_W-1:0] o_best_bid_price,
    output logic [oblu_pkg::VOL_W-1:0]   o_best_bid_volume,
    output logic [oblu_pkg::PRICE_W-1:0] o_best_ask_price,
    output logic [oblu_pkg::VOL_W-1:0]   o_best_ask_volume,
    output logic [oblu_pkg::LVL_W-1:0]   o_bid_levels,
    output logic [oblu_pkg::LVL_W-1:0]   o_ask_levels,
    output logic                         o_book_overflow,
    output logic                         o_top_valid
);
    logic                         r_cmd, r_side;
    logic [oblu_pkg::PRICE_W-1:0] r_price;
    logic [oblu_pkg::VOL_W-1:0]   r_vol;
    logic [oblu_pkg::CNT_W-1:0]   bid_cnt, ask_cnt;
    logic                         bid_ovf, ask_ovf, clr, r_last_ask;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_cmd_bit;
            r_side  <= i_side;
            r_price <= i_level_price;
            r_vol   <= i_level_volume;
        end
        if (i_cmd.apply) r_last_ask <= (r_side == oblu_pkg::SIDE_ASK);
    end

    assign clr = i_cmd.apply && (r_cmd == oblu_pkg::CMD_CLEAR);
    assign o_sts.clear = clr;

    oblu_side u_bid (
        .i_clk, .i_rst_n, .i_is_ask(1'b0), .i_clear(clr),
        .i_apply(i_cmd.apply && !r_cmd && r_side == oblu_pkg::SIDE_BID),
        .i_price(r_price), .i_volume(r_vol),
        .o_top_price(o_best_bid_price), .o_top_volume(o_best_bid_volume),
        .o_count(bid_cnt), .o_overflow(bid_ovf)
    );
    oblu_side u_ask (
        .i_clk, .i_rst_n, .i_is_ask(1'b1), .i_clear(clr),
        .i_apply(i_cmd.apply && !r_cmd && r_side == oblu_pkg::SIDE_ASK),
        .i_price(r_price), .i_volume(r_vol),
        .o_top_price(o_best_ask_price), .o_top_volume(o_best_ask_volume),
        .o_count(ask_cnt), .o_overflow(ask_ovf)
    );

    assign o_bid_levels    = oblu_pkg::LVL_W'(bid_cnt);
    assign o_ask_levels    = oblu_pkg::LVL_W'(ask_cnt);
    assign o_book_overflow = r_last_ask ? ask_ovf : bid_ovf;
    assign o_top_valid     = (bid_cnt != '0) && (ask_cnt != '0);
endmodule

@@ sv/oblu_ctrl.sv @@
// Controller: accept, apply, present result.
// Depends on oblu_pkg.
`timescale 1ns / 1ps
module oblu_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output oblu_pkg::t_dp_cmd  o_cmd,
    input  oblu_pkg::t_dp_sts  i_sts
);
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_APPLY = 3'b010,
        S_OUT   = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_APPLY;
            S_APPLY: n_state = S_OUT;
            S_OUT:   if (i_ready) n_state = i_valid ? S_APPLY : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    assign o_ready     = (r_state == S_IDLE) || (r_state == S_OUT && i_ready);
    assign o_valid     = (r_state == S_OUT);
    assign o_cmd.load  = o_ready && i_valid;
    assign o_cmd.apply = (r_state == S_APPLY);

`ifndef SYNTHESIS
    a_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_APPLY) else $error("accept lost");
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.apply |=> o_valid) else $error("no result");
    a_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.clear |-> o_cmd.apply) else $error("stray clear");
`endif
endmodule

@@ sv/order_book_level_update_top.sv @@
// Order book level update block: a depth-of-market book with bid and ask sides.
// Input channel: cmd, side, level_price, level_volume with i_valid/o_ready.
// Output channel: top of book and level counts with o_valid/i_ready.
// Each item is applied to a compare-and-shift row of cells in the controller's
// apply step and its result shows the cycle after; no new item is taken while
// an item is being applied.
// A new item is accepted in the same cycle the held result is taken.
// When the receiver stalls the result holds and no new item is taken.
// Reset empties both sides; stored levels beyond the counts are never read.
// A clear command empties both sides and reports overflow as zero.
// Depends on oblu_pkg, oblu_ctrl, oblu_dp, oblu_side.
`timescale 1ns / 1ps
module order_book_level_update_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_cmd,
    input  logic                         i_side,
    input  logic [oblu_pkg::PRICE_W-1:0] i_level_price,
    input  logic [oblu_pkg::VOL_W-1:0]   i_level_volume,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [oblu_pkg::PRICE_W-1:0] o_best_bid_price,
    output logic [oblu_pkg::VOL_W-1:0]   o_best_bid_volume,
    output logic [oblu_pkg::PRICE_W-1:0] o_best_ask_price,
    output logic [oblu_pkg::VOL_W-1:0]   o_best_ask_volume,
    output logic [oblu_pkg::LVL_W-1:0]   o_bid_levels,
    output logic [oblu_pkg::LVL_W-1:0]   o_ask_levels,
    output logic                         o_book_overflow,
    output logic                         o_top_valid
);
    oblu_pkg::t_dp_cmd cmd;
    oblu_pkg::t_dp_sts sts;

    oblu_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .o_cmd(cmd), .i_sts(sts)
    );

    oblu_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts),
        .i_cmd_bit(i_cmd), .i_side, .i_level_price, .i_level_volume,
        .o_best_bid_price, .o_best_bid_volume, .o_best_ask_price,
        .o_best_ask_volume, .o_bid_levels, .o_ask_levels,
        .o_book_overflow, .o_top_valid
    );
endmodule

@@ bench/order_book_level_update_top_tb.sv @@
// Self-checking bench for order_book_level_update_top: random and directed level updates
// are checked against a behavioral book model in this file.
// Depends on oblu_pkg and the order_book_level_update_top RTL.
`timescale 1ns / 1ps
module order_book_level_update_top_tb;
    typedef struct {
        logic                         cmd;
        logic                         side;
        logic [oblu_pkg::PRICE_W-1:0] price;
        logic [oblu_pkg::VOL_W-1:0]   volume;
    } t_level_item;

    typedef struct {
        logic [oblu_pkg::PRICE_W-1:0] bid_price;
        logic [oblu_pkg::VOL_W-1:0]   bid_volume;
        logic [oblu_pkg::PRICE_W-1:0] ask_price;
        logic [oblu_pkg::VOL_W-1:0]   ask_volume;
        logic [oblu_pkg::LVL_W-1:0]   bid_levels;
        logic [oblu_pkg::LVL_W-1:0]   ask_levels;
        logic                         overflow;
        logic                         top_valid;
    } t_top_of_book;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic                         i_cmd;
    logic                         i_side;
    logic [oblu_pkg::PRICE_W-1:0] i_level_price;
    logic [oblu_pkg::VOL_W-1:0]   i_level_volume;
    logic                         o_valid;
    logic                         i_ready;
    logic [oblu_pkg::PRICE_W-1:0] o_best_bid_price;
    logic [oblu_pkg::VOL_W-1:0]   o_best_bid_volume;
    logic [oblu_pkg::PRICE_W-1:0] o_best_ask_price;
    logic [oblu_pkg::VOL_W-1:0]   o_best_ask_volume;
    logic [oblu_pkg::LVL_W-1:0]   o_bid_levels;
    logic [oblu_pkg::LVL_W-1:0]   o_ask_levels;
    logic                         o_book_overflow;
    logic                         o_top_valid;

    order_book_level_update_top dut (.*);

    t_level_item  pending_items[$];
    t_top_of_book expected_tops[$];

    logic [oblu_pkg::PRICE_W-1:0] book_price[2][oblu_pkg::BOOK_DEPTH];
    logic [oblu_pkg::VOL_W-1:0]   book_volume[2][oblu_pkg::BOOK_DEPTH];
    int                           book_count[2];

    int  error_count;
    int  result_count;
    int  idle_cycles;
    int  sender_gap;
    int  receiver_gap;
    bit  pause_sender;
    bit  long_hold_req;
    bit  stim_done;
    logic [oblu_pkg::PRICE_W-1:0] price_base;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit ranks_first(int s, logic [oblu_pkg::PRICE_W-1:0] a,
                                       logic [oblu_pkg::PRICE_W-1:0] b);
        return (s == oblu_pkg::SIDE_ASK) ? (a < b) : (a > b);
    endfunction

    function automatic t_top_of_book apply_to_book(t_level_item it);
        t_top_of_book t;
        int s, n, i, k;
        bit ovf;
        ovf = 1'b0;
        s = it.side;
        if (it.cmd == oblu_pkg::CMD_CLEAR) begin
            book_count[0] = 0;
            book_count[1] = 0;
        end else begin
            n = book_count[s];
            for (i = 0; i < n; i++)
                if (book_price[s][i] == it.price || ranks_first(s, it.price, book_price[s][i]))
                    break;
            if (i < n && book_price[s][i] == it.price) begin
                if (it.volume != 0) begin
                    book_volume[s][i] = it.volume;
                end else begin
                    for (k = i; k + 1 < n; k++) begin
                        book_price[s][k]  = book_price[s][k+1];
                        book_volume[s][k] = book_volume[s][k+1];
                    end
                    book_count[s] = n - 1;
                end
            end else if (it.volume != 0) begin
                if (n >= oblu_pkg::BOOK_DEPTH) begin
                    ovf = 1'b1;
                    n = oblu_pkg::BOOK_DEPTH - 1;
                end
                if (i < oblu_pkg::BOOK_DEPTH) begin
                    for (k = n; k > i; k--) begin
                        book_price[s][k]  = book_price[s][k-1];
                        book_volume[s][k] = book_volume[s][k-1];
                    end
                    book_price[s][i]  = it.price;
                    book_volume[s][i] = it.volume;
                    book_count[s] = n + 1;
                end
            end
        end
        t.bid_price  = book_count[0] ? book_price[0][0] : '0;
        t.bid_volume = book_count[0] ? book_volume[0][0] : '0;
        t.ask_price  = book_count[1] ? book_price[1][0] : '0;
        t.ask_volume = book_count[1] ? book_volume[1][0] : '0;
        t.bid_levels = oblu_pkg::LVL_W'(book_count[0]);
        t.ask_levels = oblu_pkg::LVL_W'(book_count[1]);
        t.overflow   = ovf;
        t.top_valid  = (book_count[0] != 0) && (book_count[1] != 0);
        return t;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch result %0d %s: got %0h want %0h", result_count, field, got, want);
        error_count++;
    endtask

    task automatic add_item(logic c, logic s, logic [oblu_pkg::PRICE_W-1:0] p,
                            logic [oblu_pkg::VOL_W-1:0] v);
        t_level_item it;
        it.cmd = c;
        it.side = s;
        it.price = p;
        it.volume = v;
        pending_items.insert(pending_items.size(), it);
    endtask

    // random level near a moving base so that updates and deletes hit held prices
    task automatic add_random_update();
        logic [oblu_pkg::PRICE_W-1:0] p;
        logic [oblu_pkg::VOL_W-1:0]   v;
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            p = oblu_pkg::PRICE_W'({$urandom, $urandom});
        else
            p = price_base + oblu_pkg::PRICE_W'($urandom_range(0, 90));
        if ($urandom_range(0, 3) == 0)
            v = '0;
        else
            v = oblu_pkg::VOL_W'({$urandom, $urandom});
        add_item(oblu_pkg::CMD_UPDATE, 1'($urandom_range(0, 1)), p, v);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            sender_gap <= 0;
        end else if (!i_valid || o_ready) begin
            if (i_valid && o_ready)
                expected_tops.insert(expected_tops.size(),
                                     apply_to_book(pending_items.pop_front()));
            if (sender_gap > 0) begin
                i_valid <= 1'b0;
                sender_gap <= sender_gap - 1;
            end else if (pause_sender || pending_items.size() == 0) begin
                i_valid <= 1'b0;
            end else begin
                i_valid <= 1'b1;
                i_cmd <= pending_items[0].cmd;
                i_side <= pending_items[0].side;
                i_level_price <= pending_items[0].price;
                i_level_volume <= pending_items[0].volume;
                sender_gap <= pick_gap();
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_top_of_book w;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            receiver_gap <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_tops.size() == 0) begin
                    $display("unexpected result %0d", result_count);
                    error_count++;
                end else begin
                    w = expected_tops.pop_front();
                    if (o_best_bid_price !== w.bid_price)
                        report_mismatch("best_bid_price", 64'(o_best_bid_price),
                                        64'(w.bid_price));
                    if (o_best_bid_volume !== w.bid_volume)
                        report_mismatch("best_bid_volume", 64'(o_best_bid_volume),
                                        64'(w.bid_volume));
                    if (o_best_ask_price !== w.ask_price)
                        report_mismatch("best_ask_price", 64'(o_best_ask_price),
                                        64'(w.ask_price));
                    if (o_best_ask_volume !== w.ask_volume)
                        report_mismatch("best_ask_volume", 64'(o_best_ask_volume),
                                        64'(w.ask_volume));
                    if (o_bid_levels !== w.bid_levels)
                        report_mismatch("bid_levels", 64'(o_bid_levels), 64'(w.bid_levels));
                    if (o_ask_levels !== w.ask_levels)
                        report_mismatch("ask_levels", 64'(o_ask_levels), 64'(w.ask_levels));
                    if (o_book_overflow !== w.overflow)
                        report_mismatch("book_overflow", 64'(o_book_overflow),
                                        64'(w.overflow));
                    if (o_top_valid !== w.top_valid)
                        report_mismatch("top_valid", 64'(o_top_valid), 64'(w.top_valid));
                end
                result_count++;
            end
            if (long_hold_req) begin
                i_ready <= 1'b0;
                receiver_gap <= 300;
                long_hold_req <= 1'b0;
            end else if (receiver_gap > 0) begin
                i_ready <= 1'b0;
                receiver_gap <= receiver_gap - 1;
            end else if (i_ready && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                receiver_gap <= pick_gap();
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 5000) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int j;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_cmd = oblu_pkg::CMD_UPDATE;
        i_side = oblu_pkg::SIDE_BID;
        i_level_price = '0;
        i_level_volume = '0;
        pause_sender = 1'b0;
        long_hold_req = 1'b0;
        stim_done = 1'b0;
        error_count = 0;
        result_count = 0;
        book_count[0] = 0;
        book_count[1] = 0;
        price_base = 1000;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, replace, delete, absent delete, clear
        add_item(oblu_pkg::CMD_UPDATE, oblu_pkg::SIDE_BID, '0, {oblu_pkg::VOL_W{1'b1}});
        add_item(oblu_pkg::CMD_UPDATE, oblu_pkg::SIDE_BID, {oblu_pkg::PRICE_W{1'b1}}, 48'd1);
        add_item(oblu_pkg::CMD_UPDATE, oblu_pkg::SIDE_ASK, {oblu_pkg::PRICE_W{1'b1}}, 48'd5);
        add_item(oblu_pkg::CMD_UPDATE, oblu_pkg::SIDE_ASK, '0, {oblu_pkg::VOL_W{1'b1}});
        add_item(oblu_pkg::CMD_UPDATE, oblu_pkg::SIDE_ASK, 31'd50, 48'd7);
        add_item(oblu_pkg::CMD_UPDATE, oblu_pkg::SIDE_ASK, 31'd50, 48'h5555_5555_5555);
        add_item(oblu_pkg::CMD_UPDATE, oblu_pkg::SIDE_BID, 31'd50, 48'haaaa_aaaa_aaaa);
        add_item(oblu_pkg::CMD_UPDATE, oblu_pkg::SIDE_BID, 31'd77, '0);
        add_item(oblu_pkg::CMD_UPDATE, oblu_pkg::SIDE_BID, {oblu_pkg::PRICE_W{1'b1}}, '0);
        add_item(oblu_pkg::CMD_UPDATE, oblu_pkg::SIDE_ASK, '0, '0);
        add_item(oblu_pkg::CMD_CLEAR, oblu_pkg::SIDE_ASK, {oblu_pkg::PRICE_W{1'b1}},
                 {oblu_pkg::VOL_W{1'b1}});
        add_item(oblu_pkg::CMD_UPDATE, oblu_pkg::SIDE_ASK, 31'd50, '0);
        // fill both sides past depth: overflow dropping worst and dropping new level
        for (j = 0; j < oblu_pkg::BOOK_DEPTH + 4; j++) begin
            add_item(oblu_pkg::CMD_UPDATE, oblu_pkg::SIDE_BID, oblu_pkg::PRICE_W'(2000 + j),
                     oblu_pkg::VOL_W'(j + 1));
            add_item(oblu_pkg::CMD_UPDATE, oblu_pkg::SIDE_ASK, oblu_pkg::PRICE_W'(3000 - j),
                     oblu_pkg::VOL_W'(j + 1));
        end
        add_item(oblu_pkg::CMD_UPDATE, oblu_pkg::SIDE_BID, 31'd1, 48'd9);
        add_item(oblu_pkg::CMD_UPDATE, oblu_pkg::SIDE_ASK, 31'd9000, 48'd9);
        add_item(oblu_pkg::CMD_CLEAR, oblu_pkg::SIDE_BID, '0, '0);

        wait (pending_items.size() == 0);
        // long receiver hold while sender keeps offering
        for (j = 0; j < 40; j++) add_random_update();
        long_hold_req <= 1'b1;
        wait (pending_items.size() == 0);

        // sender pause until drained
        pause_sender = 1'b1;
        wait (expected_tops.size() == 0);
        pause_sender = 1'b0;

        for (j = 0; j < 1050; j++) begin
            if ($urandom_range(0, 99) < 2)
                add_item(oblu_pkg::CMD_CLEAR, 1'($urandom_range(0, 1)),
                         oblu_pkg::PRICE_W'($urandom), oblu_pkg::VOL_W'({$urandom, $urandom}));
            else
                add_random_update();
            if ($urandom_range(0, 99) == 0)
                price_base = oblu_pkg::PRICE_W'($urandom_range(0, 32'h7fff_ff00));
            if (j % 200 == 199) begin
                wait (pending_items.size() == 0);
            end
        end
        wait (pending_items.size() == 0 && !i_valid);
        wait (expected_tops.size() == 0);
        repeat (10) @(posedge i_clk);
        $display("covered %0d results across directed depth overflow, clears and random updates",
                 result_count);
        $display("errors seen: %0d", error_count);
        if (error_count == 0 && expected_tops.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
